// ===== hdl/tfis_pkg.sv =====
// shared types, codes and defaults for the time to fractional index search block
package tfis_pkg;

	localparam int DEF_TABLE_DEPTH   = 1024;
	localparam int DEF_FRACTION_BITS = 16;

	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;

	typedef enum logic [2:0] {
		STATUS_EMPTY   = 3'd0,
		STATUS_BELOW   = 3'd1,
		STATUS_ABOVE   = 3'd2,
		STATUS_LOCATED = 3'd3,
		STATUS_ACK     = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FIRST,
		ST_LAST,
		ST_START,
		ST_FWD,
		ST_BWD,
		ST_HI,
		ST_LO,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] time_value;
		logic [9:0]  start_hint;
		logic        use_hint;
	} cmd_t;

	typedef struct packed {
		status_t     status;
		logic [9:0]  index_whole;
		logic [15:0] index_fraction;
		logic [9:0]  position_out;
	} res_t;

	typedef struct packed {
		logic        start;
		logic [31:0] num;
		logic [31:0] den;
	} div_req_t;

endpackage

// ===== hdl/tfis_frac_div.sv =====
// restoring fraction divider, one quotient bit per cycle
module tfis_frac_div #(
	parameter int FRACTION_BITS = tfis_pkg::DEF_FRACTION_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  tfis_pkg::div_req_t       req,
	output logic                     done,
	output logic [FRACTION_BITS-1:0] quotient
);
	import tfis_pkg::*;

	localparam int CNTW = $clog2(FRACTION_BITS + 1);

	logic            busy_q;
	logic [CNTW-1:0] cnt_q;
	logic [31:0]     rem_q;
	logic [31:0]     den_q;
	logic [FRACTION_BITS-1:0] quo_q;
	logic [32:0]     shifted;
	logic            ge;

	assign shifted  = {rem_q, 1'b0};
	assign ge       = shifted >= {1'b0, den_q};
	assign done     = busy_q && (cnt_q == '0);
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNTW'(FRACTION_BITS);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num;
			den_q <= req.den;
			quo_q <= '0;
		end else if (busy_q && (cnt_q != '0)) begin
			if (ge) begin
				rem_q <= 32'(shifted - {1'b0, den_q});
			end else begin
				rem_q <= shifted[31:0];
			end
			quo_q <= {quo_q[FRACTION_BITS-2:0], ge};
		end
	end

endmodule

// ===== hdl/time_to_fractional_index_search.sv =====
// top level: timestamp table, hinted linear search and interpolated index
//
// cmd channel (cmd_valid / cmd_stall / cmd) carries one item: clear, append
// or query. res channel (res_valid / res_stall / res) returns one item for
// every cmd item, in order.
// clear, append and unused codes go from acceptance straight to ST_DONE.
// a query on an empty table goes straight to ST_DONE; one that clamps passes
// through ST_FIRST, or ST_FIRST and ST_LAST. a located query walks the table
// entries from the start position; the walk reads one entry per cycle from
// the table read port, then reads the two span entries, and the fraction comes
// from a restoring divider producing one bit per cycle.
// one item is worked on at a time; cmd_stall is high from acceptance until its
// result is loaded into the output register.
// a new item is accepted while the previous result still waits in the output
// register; while res_stall holds, res stays stable and the finished result of
// the next item waits internally.
// reset clears the entry count, the remembered position and the output valid;
// table contents are undefined until appended, and never read before that.
module time_to_fractional_index_search #(
	parameter int TABLE_DEPTH   = tfis_pkg::DEF_TABLE_DEPTH,
	parameter int FRACTION_BITS = tfis_pkg::DEF_FRACTION_BITS
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_stall,
	input  tfis_pkg::cmd_t cmd,
	output logic           res_valid,
	input  logic           res_stall,
	output tfis_pkg::res_t res
);
	import tfis_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int JW = (AW > 10) ? AW : 10;

	logic [31:0] mem [TABLE_DEPTH];

	state_t      state_q, state_d;
	logic [CW-1:0] count_q;
	logic [AW-1:0] lastpos_q;
	logic [AW-1:0] j_q, j_d;
	cmd_t        item_q;
	res_t        pending_q;
	res_t        res_q;
	logic        res_valid_q;
	logic [31:0] hi_q;
	logic [31:0] rd_data_q;

	logic          take;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic          wr_en;
	logic [AW-1:0] last;
	logic [JW-1:0] pos_sel;
	logic [AW-1:0] start_j;
	logic          gt, lt;
	logic          load_out;
	div_req_t      div_req;
	logic          div_done;
	logic [FRACTION_BITS-1:0] div_q;

	function automatic logic [AW-1:0] jfix(input logic [AW-1:0] j);
		jfix = (j == '0) ? AW'(1) : j;
	endfunction

	assign cmd_stall = (state_q != ST_IDLE);
	assign take      = cmd_valid && !cmd_stall;
	assign wr_en     = take && (cmd.operation == OP_APPEND) && (count_q < CW'(TABLE_DEPTH));
	assign last      = AW'(count_q - 1'b1);
	assign pos_sel   = item_q.use_hint ? JW'(item_q.start_hint) : JW'(lastpos_q);
	assign start_j   = (pos_sel > JW'(last)) ? last : pos_sel[AW-1:0];
	assign gt        = item_q.time_value > rd_data_q;
	assign lt        = item_q.time_value < rd_data_q;
	assign load_out  = (state_q == ST_DONE) && (!res_valid_q || !res_stall);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	tfis_frac_div #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (div_req),
		.done    (div_done),
		.quotient(div_q)
	);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[count_q[AW-1:0]] <= cmd.time_value;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_comb begin
		state_d       = state_q;
		rd_en         = 1'b0;
		rd_addr       = '0;
		j_d           = j_q;
		div_req.start = 1'b0;
		div_req.num   = 32'(item_q.time_value - rd_data_q);
		div_req.den   = 32'(hi_q - rd_data_q);
		unique case (state_q)
			ST_IDLE: begin
				if (take) begin
					if (cmd.operation == OP_QUERY && count_q != '0) begin
						rd_en   = 1'b1;
						state_d = ST_FIRST;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_FIRST: begin
				if (!gt) begin
					state_d = ST_DONE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = last;
					state_d = ST_LAST;
				end
			end
			ST_LAST: begin
				if (!lt) begin
					state_d = ST_DONE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = start_j;
					j_d     = start_j;
					state_d = ST_START;
				end
			end
			ST_START, ST_FWD: begin
				rd_en = 1'b1;
				if (gt && j_q < last) begin
					j_d     = j_q + 1'b1;
					state_d = ST_FWD;
				end else if (state_q == ST_START && lt && j_q != '0) begin
					j_d     = j_q - 1'b1;
					state_d = ST_BWD;
				end else if (state_q == ST_START && lt) begin
					j_d     = AW'(1);
					state_d = ST_HI;
				end else begin
					j_d     = jfix(j_q);
					state_d = ST_HI;
				end
				rd_addr = j_d;
			end
			ST_BWD: begin
				rd_en = 1'b1;
				if (lt && j_q != '0) begin
					j_d = j_q - 1'b1;
				end else begin
					j_d     = j_q + 1'b1;
					state_d = ST_HI;
				end
				rd_addr = j_d;
			end
			ST_HI: begin
				rd_en   = 1'b1;
				rd_addr = j_q - 1'b1;
				state_d = ST_LO;
			end
			ST_LO: begin
				if (item_q.time_value >= hi_q || !gt) begin
					state_d = ST_DONE;
				end else begin
					div_req.start = 1'b1;
					state_d       = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			lastpos_q   <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (take && cmd.operation == OP_CLEAR) begin
				count_q   <= '0;
				lastpos_q <= '0;
			end else if (wr_en) begin
				count_q <= count_q + 1'b1;
			end
			if (state_q == ST_HI) begin
				lastpos_q <= j_q;
			end
			if (load_out) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		j_q <= j_d;
		if (take) begin
			item_q    <= cmd;
			pending_q <= '{status: (cmd.operation == OP_QUERY && count_q == '0) ?
				STATUS_EMPTY : STATUS_ACK, index_whole: '0, index_fraction: '0,
				position_out: '0};
		end
		if (state_q == ST_FIRST && !gt) begin
			pending_q <= '{status: STATUS_BELOW, index_whole: '0, index_fraction: '0,
				position_out: '0};
		end
		if (state_q == ST_LAST && !lt) begin
			pending_q <= '{status: STATUS_ABOVE, index_whole: 10'(last), index_fraction: '0,
				position_out: 10'(last)};
		end
		if (state_q == ST_HI) begin
			hi_q <= rd_data_q;
		end
		if (state_q == ST_LO) begin
			pending_q <= '{status: STATUS_LOCATED,
				index_whole: (item_q.time_value >= hi_q) ? 10'(j_q) : 10'(j_q - 1'b1),
				index_fraction: '0, position_out: 10'(j_q)};
		end
		if (state_q == ST_DIV && div_done) begin
			pending_q.index_fraction <= 16'(div_q);
		end
		if (load_out) begin
			res_q <= pending_q;
		end
	end

endmodule

// ===== hdl/tfis_check.sv =====
// port checker for the time to fractional index search block, with its bind
module tfis_check (
	input logic           clk,
	input logic           arst_n,
	input logic           cmd_valid,
	input logic           cmd_stall,
	input tfis_pkg::cmd_t cmd,
	input logic           res_valid,
	input logic           res_stall,
	input tfis_pkg::res_t res
);
	import tfis_pkg::*;

	a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> cmd_stall)
		else $error("item accepted while another is in work");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("stalled result changed");

	a_clamped_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.status == STATUS_EMPTY || res.status == STATUS_BELOW ||
		res.status == STATUS_ACK) |-> res.index_whole == '0 && res.index_fraction == '0 &&
		res.position_out == '0)
		else $error("non-located result carries index data");

	a_located_span: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status == STATUS_LOCATED |->
		(res.position_out == res.index_whole && res.index_fraction == '0) ||
		res.position_out == 10'(res.index_whole + 10'd1))
		else $error("located position not next to whole index");

	a_above_same: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status == STATUS_ABOVE |->
		res.position_out == res.index_whole && res.index_fraction == '0)
		else $error("above-last result inconsistent");

endmodule

bind time_to_fractional_index_search tfis_check u_tfis_check (.*);

// ===== dv/time_to_fractional_index_search_tb.sv =====
// testbench for the timestamp search block: directed table, then random table builds and queries
`timescale 1ns / 1ps

module time_to_fractional_index_search_tb;
	import tfis_pkg::*;

	localparam int TABLE_DEPTH = DEF_TABLE_DEPTH;
	localparam int FRAC_BITS = DEF_FRACTION_BITS;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 4000000;
	localparam int PHASE_ITEMS = 160;
	localparam int FILL_ENTRIES = 300;

	typedef struct {
		cmd_t item;
		bit   typed;
		res_t want;
	} row_t;

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	cmd_t cmd;
	logic res_valid;
	logic res_stall;
	res_t res;

	// predictor state
	logic [31:0] time_tbl [TABLE_DEPTH];
	int unsigned entry_total = 0;
	logic [9:0] remembered_pos = '0;

	res_t pending_results [$];
	logic [31:0] built_times [$];
	row_t directed_rows [$];
	bit typed_hold;
	res_t typed_res;
	res_t predicted;
	res_t oldest;
	int idle_pct;
	int stall_pct;
	int error_count = 0;
	int accepted_count = 0;
	int checked_count = 0;
	int located_count = 0;
	int clamped_count = 0;

	time_to_fractional_index_search #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.FRACTION_BITS(FRAC_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic res_t locate_time(input cmd_t c);
		res_t r;
		int unsigned last_idx;
		int unsigned j;
		logic [31:0] t;
		logic [31:0] lo;
		logic [31:0] hi;
		logic [63:0] quot;
		r = '0;
		r.status = STATUS_ACK;
		t = c.time_value;
		case (c.operation)
			OP_CLEAR: begin
				entry_total = 0;
				remembered_pos = '0;
			end
			OP_APPEND: begin
				if (entry_total < TABLE_DEPTH) begin
					time_tbl[entry_total] = t;
					entry_total++;
				end
			end
			OP_QUERY: begin
				if (entry_total == 0) begin
					r.status = STATUS_EMPTY;
				end else begin
					last_idx = entry_total - 1;
					if (t <= time_tbl[0]) begin
						r.status = STATUS_BELOW;
					end else if (t >= time_tbl[last_idx]) begin
						r.status = STATUS_ABOVE;
						r.index_whole = 10'(last_idx);
						r.position_out = 10'(last_idx);
					end else begin
						j = c.use_hint ? c.start_hint : remembered_pos;
						if (j > last_idx)
							j = last_idx;
						if (t > time_tbl[j]) begin
							while (j < last_idx && t > time_tbl[j])
								j++;
						end else if (t < time_tbl[j]) begin
							while (j > 0 && t < time_tbl[j])
								j--;
							j++;
						end
						if (j < 1)
							j = 1;
						if (j > last_idx)
							j = last_idx;
						remembered_pos = 10'(j);
						lo = time_tbl[j - 1];
						hi = time_tbl[j];
						r.status = STATUS_LOCATED;
						r.position_out = 10'(j);
						if (t >= hi) begin
							r.index_whole = 10'(j);
						end else begin
							r.index_whole = 10'(j - 1);
							if (t > lo) begin
								quot = ({32'd0, t - lo} << FRAC_BITS) / {32'd0, hi - lo};
								r.index_fraction = quot[15:0];
							end
						end
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
		error_count++;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_valid && !cmd_stall) begin
				predicted = locate_time(cmd);
				pending_results.insert(pending_results.size(),
					typed_hold ? typed_res : predicted);
				accepted_count++;
			end
			if (res_valid && !res_stall) begin
				if (pending_results.size() == 0) begin
					report_mismatch("item with nothing pending", res, '0);
				end else begin
					oldest = pending_results.pop_front();
					checked_count++;
					if (oldest.status == STATUS_LOCATED)
						located_count++;
					if (oldest.status == STATUS_BELOW || oldest.status == STATUS_ABOVE)
						clamped_count++;
					if (res.status != oldest.status)
						report_mismatch("status", res.status, oldest.status);
					if (res.index_whole != oldest.index_whole)
						report_mismatch("index_whole", res.index_whole, oldest.index_whole);
					if (res.index_fraction != oldest.index_fraction)
						report_mismatch("index_fraction", res.index_fraction,
							oldest.index_fraction);
					if (res.position_out != oldest.position_out)
						report_mismatch("position_out", res.position_out, oldest.position_out);
				end
			end
		end
	end

	always @(negedge clk)
		res_stall <= ($urandom_range(99) < stall_pct);

	task automatic send_item(input cmd_t c, input bit typed, input res_t want);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
		end
		typed_hold = typed;
		typed_res = want;
		cmd <= c;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
	endtask

	task automatic issue(input logic [1:0] op, input logic [31:0] t, input logic [9:0] hint,
			input logic use_h);
		cmd_t c;
		c.operation = op;
		c.time_value = t;
		c.start_hint = hint;
		c.use_hint = use_h;
		send_item(c, 1'b0, '0);
	endtask

	task automatic drain_results();
		@(negedge clk);
		cmd_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic add_row(input logic [1:0] op, input logic [31:0] t, input logic [9:0] hint,
			input logic use_h, input bit typed, input status_t st, input int whole,
			input int pos);
		row_t row;
		row.item.operation = op;
		row.item.time_value = t;
		row.item.start_hint = hint;
		row.item.use_hint = use_h;
		row.typed = typed;
		row.want = '0;
		row.want.status = st;
		row.want.index_whole = 10'(whole);
		row.want.position_out = 10'(pos);
		directed_rows.insert(directed_rows.size(), row);
	endtask

	function automatic logic [31:0] pick_query_time();
		int n;
		int k;
		int roll;
		logic [31:0] lo;
		logic [31:0] hi;
		n = built_times.size();
		roll = $urandom_range(99);
		if (n == 0 || roll < 12)
			return $urandom;
		k = $urandom_range(n - 1);
		if (roll < 24)
			return built_times[k];
		if (roll < 30)
			return (roll < 27) ? built_times[0] : built_times[n - 1];
		if (n < 2)
			return built_times[0] + $urandom_range(2) - 1;
		k = $urandom_range(1, n - 1);
		lo = built_times[k - 1];
		hi = built_times[k];
		if (hi > lo)
			return lo + $urandom_range(0, hi - lo);
		return lo;
	endfunction

	function automatic logic [9:0] pick_hint();
		int n;
		n = built_times.size();
		if (n > 0 && $urandom_range(99) < 70)
			return 10'((n >= TABLE_DEPTH) ? $urandom_range(TABLE_DEPTH - 1) : $urandom_range(n));
		return 10'($urandom_range(1023));
	endfunction

	task automatic add_entry(input logic [31:0] t);
		issue(OP_APPEND, t, 10'($urandom_range(1023)), 1'($urandom_range(1)));
		if (built_times.size() < TABLE_DEPTH)
			built_times.insert(built_times.size(), t);
	endtask

	task automatic run_phase(input int target);
		int done_items;
		int n_app;
		int n_qry;
		int i;
		logic [31:0] t;
		logic [31:0] step;
		done_items = 0;
		while (done_items < target) begin
			if ($urandom_range(99) < 80) begin
				issue(OP_CLEAR, $urandom, 10'($urandom_range(1023)), 1'($urandom_range(1)));
				built_times.delete();
				done_items++;
			end
			n_app = ($urandom_range(9) == 0) ? 0 :
				(($urandom_range(9) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 24));
			for (i = 0; i < n_app; i++) begin
				if ($urandom_range(99) < 5) begin
					t = $urandom;
				end else if (built_times.size() == 0) begin
					t = ($urandom_range(99) < 20) ? $urandom : $urandom_range(0, 32'h00FF_FFFF);
				end else begin
					step = ($urandom_range(9) == 0) ? 0 :
						$urandom_range(1, 1 << $urandom_range(0, 20));
					t = built_times[built_times.size() - 1] + step;
				end
				add_entry(t);
			end
			n_qry = $urandom_range(1, 12);
			for (i = 0; i < n_qry; i++) begin
				issue(OP_QUERY, pick_query_time(), pick_hint(), 1'($urandom_range(1)));
				if ($urandom_range(99) < 3)
					issue(OP_UNUSED, $urandom, 10'($urandom_range(1023)), 1'($urandom_range(1)));
			end
			done_items += n_app + n_qry;
		end
	endtask

	task automatic fill_table();
		int i;
		logic [31:0] t;
		issue(OP_CLEAR, '0, '0, 1'b0);
		built_times.delete();
		t = $urandom_range(0, 1 << 20);
		for (i = 0; i < FILL_ENTRIES; i++) begin
			add_entry(t);
			t = t + $urandom_range(1, 1 << 21);
		end
		for (i = 0; i < 24; i++)
			issue(OP_QUERY, pick_query_time(), pick_hint(), 1'($urandom_range(1)));
		issue(OP_QUERY, 32'hFFFF_FFFF, 10'h3FF, 1'b1);
	endtask

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		typed_hold = 1'b0;
		typed_res = '0;
		idle_pct = 20;
		stall_pct = 84;

		add_row(OP_QUERY, 32'h0000_0000, 10'd0, 1'b0, 1'b1, STATUS_EMPTY, 0, 0);
		add_row(OP_UNUSED, 32'hFFFF_FFFF, 10'h3FF, 1'b1, 1'b1, STATUS_ACK, 0, 0);
		add_row(OP_CLEAR, 32'h0000_0000, 10'd0, 1'b0, 1'b1, STATUS_ACK, 0, 0);
		add_row(OP_APPEND, 32'h0001_0000, 10'd0, 1'b0, 1'b1, STATUS_ACK, 0, 0);
		add_row(OP_QUERY, 32'h0000_0000, 10'd0, 1'b0, 1'b1, STATUS_BELOW, 0, 0);
		add_row(OP_QUERY, 32'hFFFF_FFFF, 10'h3FF, 1'b1, 1'b1, STATUS_ABOVE, 0, 0);
		add_row(OP_QUERY, 32'h0001_0000, 10'd0, 1'b1, 1'b1, STATUS_BELOW, 0, 0);
		add_row(OP_APPEND, 32'h0002_0000, 10'd0, 1'b0, 1'b1, STATUS_ACK, 0, 0);
		add_row(OP_APPEND, 32'h0004_0000, 10'd0, 1'b0, 1'b1, STATUS_ACK, 0, 0);
		add_row(OP_APPEND, 32'h0004_0000, 10'd0, 1'b0, 1'b1, STATUS_ACK, 0, 0);
		add_row(OP_APPEND, 32'h0008_0000, 10'd0, 1'b0, 1'b1, STATUS_ACK, 0, 0);
		add_row(OP_QUERY, 32'h0003_0000, 10'd0, 1'b1, 1'b0, STATUS_LOCATED, 0, 0);
		add_row(OP_QUERY, 32'h0002_0000, 10'h3FF, 1'b1, 1'b0, STATUS_LOCATED, 0, 0);
		add_row(OP_QUERY, 32'h0005_0000, 10'd0, 1'b0, 1'b0, STATUS_LOCATED, 0, 0);
		add_row(OP_QUERY, 32'h0004_0000, 10'd0, 1'b1, 1'b0, STATUS_LOCATED, 0, 0);
		add_row(OP_QUERY, 32'h0001_8000, 10'd4, 1'b1, 1'b0, STATUS_LOCATED, 0, 0);
		add_row(OP_QUERY, 32'h0008_0000, 10'd2, 1'b0, 1'b1, STATUS_ABOVE, 4, 4);
		// out of order entry at the end of the table
		add_row(OP_APPEND, 32'h0003_0000, 10'd0, 1'b0, 1'b1, STATUS_ACK, 0, 0);
		add_row(OP_QUERY, 32'h0002_8000, 10'd4, 1'b1, 1'b0, STATUS_LOCATED, 0, 0);
		add_row(OP_QUERY, 32'h0002_0001, 10'd5, 1'b0, 1'b0, STATUS_LOCATED, 0, 0);
		add_row(OP_QUERY, 32'h0001_0001, 10'h200, 1'b1, 1'b0, STATUS_LOCATED, 0, 0);
		add_row(OP_CLEAR, 32'hFFFF_FFFF, 10'h3FF, 1'b1, 1'b1, STATUS_ACK, 0, 0);
		add_row(OP_QUERY, 32'hFFFF_FFFF, 10'd0, 1'b0, 1'b1, STATUS_EMPTY, 0, 0);
		add_row(OP_APPEND, 32'hFFFF_FFFF, 10'd0, 1'b0, 1'b1, STATUS_ACK, 0, 0);
		add_row(OP_QUERY, 32'hFFFF_FFFF, 10'd0, 1'b0, 1'b1, STATUS_BELOW, 0, 0);

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i])
			send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
		run_phase(PHASE_ITEMS);
		drain_results();

		idle_pct = 84;
		stall_pct = 20;
		run_phase(PHASE_ITEMS);
		drain_results();

		idle_pct = 0;
		stall_pct = 0;
		fill_table();
		run_phase(PHASE_ITEMS);
		drain_results();
		repeat (50) @(posedge clk);

		$display("covered %0d items and %0d results: %0d located, %0d clamped queries",
			accepted_count, checked_count, located_count, clamped_count);
		$display("tables from empty up to %0d entries, hinted and remembered starts, %0d mismatches",
			FILL_ENTRIES, error_count);
		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/tfis_pkg.sv
hdl/tfis_frac_div.sv
hdl/time_to_fractional_index_search.sv
hdl/tfis_check.sv
dv/time_to_fractional_index_search_tb.sv
